### sv/circular_queue_controller_assert.svh
// Assertion macros shared by the circular queue checker.
`ifndef CIRCULAR_QUEUE_CONTROLLER_ASSERT_SVH
`define CIRCULAR_QUEUE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define CQC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define CQC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/cqc_pkg.sv
// Shared types and codes of the circular queue controller.
package cqc_pkg;

	localparam int CAP_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_DISP = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_REPLY  = 3'b010,
		S_STREAM = 3'b100
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic    cfg_wr;
		logic    enq;
		logic    deq;
		logic    rd_head;
		logic    rd_all;
		logic    rd_next;
		logic    set_status;
		status_t status;
		logic    load_reply;
		logic    load_data;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic empty;
		logic full;
		logic cnt_last;
		logic out_free;
	} sts_t;

endpackage

### sv/cqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/cqc_datapath.sv
// Queue pointers, occupancy, slot memory and output word register.
module cqc_datapath #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cqc_pkg::cmd_t                      cmd,
	output cqc_pkg::sts_t                      sts,
	input  logic signed [cqc_pkg::VALUE_W-1:0] push_value,
	input  logic [cqc_pkg::CAP_W-1:0]          cfg_data,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [cqc_pkg::STATUS_W-1:0]       status,
	output logic signed [cqc_pkg::VALUE_W-1:0] read_value,
	output logic                               is_empty,
	output logic                               is_full,
	output logic                               last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CAP_W = cqc_pkg::CAP_W;

	logic [IDX_W-1:0]      head_q, tail_q, rd_idx_q;
	logic [OCC_W-1:0]      occ_q, cnt_q;
	logic [CAP_W-1:0]      cap_q, cap_sat;
	cqc_pkg::status_t      status_q;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [IDX_W-1:0]      rd_addr;
	logic                  rd_en;
	logic                  empty, full, out_free;

	logic                               out_valid_q;
	cqc_pkg::status_t                   out_status_q;
	logic [cqc_pkg::VALUE_W-1:0]        out_value_q;
	logic                               out_empty_q, out_full_q, out_last_q;

	// Advance an index, back to zero at the capacity.
	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] n;
		n = CAP_W'(idx) + CAP_W'(1);
		return (n >= cap) ? '0 : IDX_W'(n);
	endfunction

	assign empty    = (occ_q == '0);
	assign full     = (CAP_W'(occ_q) >= cap_q);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.empty    = empty;
	assign sts.full     = full;
	assign sts.cnt_last = (cnt_q == OCC_W'(1));
	assign sts.out_free = out_free;

	// Clamp the written capacity into 1..DEPTH.
	always_comb begin
		priority if (cfg_data == '0) begin
			cap_sat = CAP_W'(1);
		end else if (cfg_data > CAP_W'(DEPTH)) begin
			cap_sat = CAP_W'(DEPTH);
		end else begin
			cap_sat = cfg_data;
		end
	end

	assign rd_en   = cmd.rd_head || cmd.rd_next;
	assign rd_addr = cmd.rd_head ? head_q : rd_idx_q;

	cqc_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (cmd.enq),
		.wr_addr (tail_q),
		.wr_data (DATA_WIDTH'(push_value)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(DEPTH);
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q  <= cap_sat;
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			if (cmd.enq) begin
				tail_q <= wrap_next(tail_q, cap_q);
				occ_q  <= occ_q + OCC_W'(1);
			end
			if (cmd.deq) begin
				occ_q <= occ_q - OCC_W'(1);
				if (occ_q == OCC_W'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end else begin
					head_q <= wrap_next(head_q, cap_q);
				end
			end
		end
	end

	// Read cursor and remaining count of the current stream.
	always_ff @(posedge clk) begin
		if (cmd.rd_head) begin
			rd_idx_q <= wrap_next(head_q, cap_q);
			cnt_q    <= cmd.rd_all ? occ_q : OCC_W'(1);
		end else if (cmd.rd_next) begin
			rd_idx_q <= wrap_next(rd_idx_q, cap_q);
			cnt_q    <= cnt_q - OCC_W'(1);
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_reply || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_reply) begin
			out_status_q <= status_q;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.load_data) begin
			out_status_q <= cqc_pkg::ST_DONE;
			out_value_q  <= cqc_pkg::VALUE_W'(rd_data);
			out_last_q   <= sts.cnt_last;
		end
		if (cmd.load_reply || cmd.load_data) begin
			out_empty_q <= empty;
			out_full_q  <= full;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_value_q;
	assign is_empty   = out_empty_q;
	assign is_full    = out_full_q;
	assign last       = out_last_q;

endmodule

### sv/cqc_ctrl.sv
// Request sequencer of the circular queue controller.
module cqc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cqc_pkg::OP_W-1:0]    op,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	output cqc_pkg::cmd_t               cmd,
	input  cqc_pkg::sts_t               sts
);

	cqc_pkg::state_t state_q, state_d;

	// A capacity write offered in the same cycle goes first: hold the request.
	assign in_stall  = (state_q != cqc_pkg::S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == cqc_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cqc_pkg::S_IDLE: begin
				cmd.cfg_wr = cfg_valid;
				if (in_valid && !cfg_valid) begin
					cmd.set_status = 1'b1;
					unique case (cqc_pkg::op_t'(op))
						cqc_pkg::OP_ENQ: begin
							state_d = cqc_pkg::S_REPLY;
							if (sts.full) begin
								cmd.status = cqc_pkg::ST_FULL;
							end else begin
								cmd.enq    = 1'b1;
								cmd.status = cqc_pkg::ST_DONE;
							end
						end
						default: begin
							if (sts.empty) begin
								cmd.status = cqc_pkg::ST_EMPTY;
								state_d    = cqc_pkg::S_REPLY;
							end else begin
								cmd.rd_head = 1'b1;
								cmd.rd_all  = (cqc_pkg::op_t'(op) == cqc_pkg::OP_DISP);
								cmd.deq     = (cqc_pkg::op_t'(op) == cqc_pkg::OP_DEQ);
								state_d     = cqc_pkg::S_STREAM;
							end
						end
					endcase
				end
			end
			cqc_pkg::S_REPLY: begin
				if (sts.out_free) begin
					cmd.load_reply = 1'b1;
					state_d        = cqc_pkg::S_IDLE;
				end
			end
			cqc_pkg::S_STREAM: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					if (sts.cnt_last) begin
						state_d = cqc_pkg::S_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = cqc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/circular_queue_controller.sv
// Circular queue controller top level: sequencer plus queue datapath.
//
// A bounded FIFO of signed values held in one single-port-read RAM of DEPTH
// slots, of which the capacity register enables 1..DEPTH (0 reads as 1, values
// above DEPTH as DEPTH). A capacity write empties the queue; write it only
// while no request is in flight. Each request word (op, push_value) returns
// result words on the output channel, each with status, read_value, is_empty,
// is_full and last. Enqueue, and any rejected request: accept, then load the
// output register. Dequeue and peek: accept and address the slot RAM, then
// load its registered read data. Display delivers the stored values through
// the single RAM read port, one slot per cycle while the output is not
// stalled, oldest first, with last on the newest. A new request is taken
// while the final result word still waits in the output register. No
// clearing pass after reset: slots are only ever read after they were
// written.
module circular_queue_controller #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cqc_pkg::OP_W-1:0]           op,
	input  logic signed [cqc_pkg::VALUE_W-1:0] push_value,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cqc_pkg::STATUS_W-1:0]       status,
	output logic signed [cqc_pkg::VALUE_W-1:0] read_value,
	output logic                               is_empty,
	output logic                               is_full,
	output logic                               last,
	// capacity register write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cqc_pkg::CAP_W-1:0]          capacity
);

	cqc_pkg::cmd_t cmd;
	cqc_pkg::sts_t sts;

	// Sequence each request: decode, reply, or stream slots out.
	cqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Hold pointers, occupancy, slots and the output word.
	cqc_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.push_value (push_value),
		.cfg_data   (capacity),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.read_value (read_value),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.last       (last)
	);

endmodule

### sv/cqc_checker.sv
// Port-level checker for the circular queue controller, bound to the top.
`include "circular_queue_controller_assert.svh"

module cqc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [cqc_pkg::STATUS_W-1:0]       status,
	input logic signed [cqc_pkg::VALUE_W-1:0] read_value,
	input logic                               is_empty,
	input logic                               is_full,
	input logic                               last
);

	`CQC_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "request taken without going busy")
	`CQC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value), "stalled result word changed")
	`CQC_ASSERT_IMP(a_flags_excl, out_valid, !(is_empty && is_full), "queue flagged both empty and full")
	`CQC_ASSERT_IMP(a_reject_flags, out_valid && (status == cqc_pkg::ST_FULL), is_full && last, "full rejection without full flag")
	`CQC_ASSERT_NXT(a_stream_gap, out_valid && !out_stall && !last, out_valid, "display stream left a gap")

endmodule

bind circular_queue_controller cqc_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.read_value (read_value),
	.is_empty   (is_empty),
	.is_full    (is_full),
	.last       (last)
);

### tb/sv/queue_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the circular queue controller: queue prediction and result word compare.
module queue_result_checker #(
	parameter int DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [cqc_pkg::OP_W-1:0]           op,
	input  logic signed [cqc_pkg::VALUE_W-1:0] push_value,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [cqc_pkg::STATUS_W-1:0]       status,
	input  logic signed [cqc_pkg::VALUE_W-1:0] read_value,
	input  logic                               is_empty,
	input  logic                               is_full,
	input  logic                               last,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [cqc_pkg::CAP_W-1:0]          cfg_capacity,
	output int                                 fail_count,
	output int                                 pending_words
);

	typedef struct {
		cqc_pkg::status_t                    status;
		logic signed [cqc_pkg::VALUE_W-1:0]  value;
		logic                                empty;
		logic                                full;
		logic                                last;
	} result_word_t;

	result_word_t                       expected_words[$];
	logic signed [cqc_pkg::VALUE_W-1:0] slot_model[DEPTH];
	int                                 head_slot;
	int                                 tail_slot;
	int                                 stored_count;
	int                                 cap_limit;

	// wrap by compare against the live capacity
	function automatic int next_slot(int idx);
		return (idx + 1 >= cap_limit) ? 0 : idx + 1;
	endfunction

	function automatic void expect_word(cqc_pkg::status_t st,
		logic signed [cqc_pkg::VALUE_W-1:0] value, logic is_final);
		result_word_t w;
		w.status = st;
		w.value  = value;
		w.empty  = (stored_count == 0);
		w.full   = (stored_count >= cap_limit);
		w.last   = is_final;
		expected_words.push_back(w);
	endfunction

	function automatic void apply_capacity(logic [cqc_pkg::CAP_W-1:0] value);
		cap_limit    = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : int'(value);
		head_slot    = 0;
		tail_slot    = 0;
		stored_count = 0;
	endfunction

	function automatic void predict_request(cqc_pkg::op_t code,
		logic signed [cqc_pkg::VALUE_W-1:0] value);
		logic signed [cqc_pkg::VALUE_W-1:0] oldest;
		int                                 idx;
		if (code == cqc_pkg::OP_ENQ) begin
			if (stored_count >= cap_limit) begin
				expect_word(cqc_pkg::ST_FULL, '0, 1'b1);
			end else begin
				slot_model[tail_slot] = value;
				tail_slot = next_slot(tail_slot);
				stored_count++;
				expect_word(cqc_pkg::ST_DONE, '0, 1'b1);
			end
		end else if (stored_count == 0) begin
			expect_word(cqc_pkg::ST_EMPTY, '0, 1'b1);
		end else begin
			case (code)
				cqc_pkg::OP_DEQ: begin
					oldest = slot_model[head_slot];
					stored_count--;
					// drained queue snaps both indexes home
					if (stored_count == 0) begin
						head_slot = 0;
						tail_slot = 0;
					end else begin
						head_slot = next_slot(head_slot);
					end
					expect_word(cqc_pkg::ST_DONE, oldest, 1'b1);
				end
				cqc_pkg::OP_PEEK: begin
					expect_word(cqc_pkg::ST_DONE, slot_model[head_slot], 1'b1);
				end
				default: begin
					idx = head_slot;
					for (int i = 0; i < stored_count; i++) begin
						expect_word(cqc_pkg::ST_DONE, slot_model[idx], i + 1 == stored_count);
						idx = next_slot(idx);
					end
				end
			endcase
		end
	endfunction

	function automatic void check_field(string field, logic [cqc_pkg::VALUE_W-1:0] want,
		logic [cqc_pkg::VALUE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			cap_limit     = DEPTH;
			head_slot     = 0;
			tail_slot     = 0;
			stored_count  = 0;
			fail_count    = 0;
			pending_words = 0;
			expected_words.delete();
		end else begin
			// retire the word leaving the block before adding new expectations
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got status %0d value %0h",
						$time, status, read_value);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("status", cqc_pkg::VALUE_W'(want.status),
						cqc_pkg::VALUE_W'(status));
					check_field("read_value", want.value, read_value);
					check_field("is_empty", cqc_pkg::VALUE_W'(want.empty),
						cqc_pkg::VALUE_W'(is_empty));
					check_field("is_full", cqc_pkg::VALUE_W'(want.full),
						cqc_pkg::VALUE_W'(is_full));
					check_field("last", cqc_pkg::VALUE_W'(want.last),
						cqc_pkg::VALUE_W'(last));
				end
			end
			if (cfg_valid && cfg_ready)
				apply_capacity(cfg_capacity);
			if (in_valid && !in_stall)
				predict_request(cqc_pkg::op_t'(op), push_value);
			pending_words = expected_words.size();
		end
	end

endmodule

### tb/sv/tb_circular_queue_controller.sv
`timescale 1ns / 100ps
// Testbench top for the circular queue controller: clock, reset, stimulus and verdict.
module tb_circular_queue_controller;

	localparam int DEPTH       = 64;
	localparam int HOLD_CYCLES = 90;
	localparam int PHASES      = 9;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [cqc_pkg::OP_W-1:0]           op;
	logic signed [cqc_pkg::VALUE_W-1:0] push_value;
	logic                               out_valid;
	logic                               out_stall;
	logic [cqc_pkg::STATUS_W-1:0]       status;
	logic signed [cqc_pkg::VALUE_W-1:0] read_value;
	logic                               is_empty;
	logic                               is_full;
	logic                               last;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [cqc_pkg::CAP_W-1:0]          cap_wdata;

	int fail_count;
	int pending_words;

	// stimulus shaping: idle rate, long receiver hold, and a rough fill level
	// used only to steer the op mix between filling and draining
	bit quiet_run;
	bit hold_request;
	int idle_pct;
	int cap_now;
	int fill_level;
	bit filling;

	always #10 clk = ~clk;

	circular_queue_controller #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (cqc_pkg::VALUE_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (cap_wdata)
	);

	queue_result_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_value    (read_value),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_capacity  (cap_wdata),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	// Offer one request word and hold it until the block takes it.
	task automatic send_word(input cqc_pkg::op_t code,
		input logic signed [cqc_pkg::VALUE_W-1:0] value);
		int gap;
		if (!quiet_run && $urandom_range(0, 99) < idle_pct) begin
			// drop valid for a burst and scramble the idle payload
			in_valid   <= 1'b0;
			op         <= cqc_pkg::OP_W'($urandom_range(0, 3));
			push_value <= $urandom();
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= code;
		push_value <= value;
		do @(posedge clk); while (in_stall);
		case (code)
			cqc_pkg::OP_ENQ:  if (fill_level < cap_now) fill_level++;
			cqc_pkg::OP_DEQ:  if (fill_level > 0) fill_level--;
			default: ;
		endcase
	endtask

	// Stop offering and wait until every expected result word has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register; only ever done with the queue idle.
	task automatic write_capacity(input logic [cqc_pkg::CAP_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cap_wdata <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cap_now    = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : int'(value);
		fill_level = 0;
		filling    = 1'b1;
	endtask

	// Enqueue-heavy while filling, dequeue-heavy while draining.
	function automatic cqc_pkg::op_t next_request_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (filling)
			return (roll < 80) ? cqc_pkg::OP_ENQ : (roll < 85) ? cqc_pkg::OP_DEQ :
				(roll < 93) ? cqc_pkg::OP_PEEK : cqc_pkg::OP_DISP;
		return (roll < 15) ? cqc_pkg::OP_ENQ : (roll < 75) ? cqc_pkg::OP_DEQ :
			(roll < 88) ? cqc_pkg::OP_PEEK : cqc_pkg::OP_DISP;
	endfunction

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// hold off long enough for the block to back up its input
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall    <= 1'b0;
				hold_request = 1'b0;
			end else if (!quiet_run && $urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int phase_caps[PHASES]  = '{1, 2, 0, 5, 127, 3, 64, 20, 2};
		int phase_items[PHASES] = '{30, 30, 20, 40, 140, 30, 60, 50, 20};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = cqc_pkg::OP_ENQ;
		push_value   = '0;
		cfg_valid    = 1'b0;
		cap_wdata    = '0;
		quiet_run    = 1'b0;
		hold_request = 1'b0;
		idle_pct     = 20;
		cap_now      = DEPTH;
		fill_level   = 0;
		filling      = 1'b1;
		phase_caps[7] = $urandom_range(6, 40);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue at reset capacity: every read kind is rejected
		send_word(cqc_pkg::OP_PEEK, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_DISP, $urandom());
		send_word(cqc_pkg::OP_ENQ, 32'sh7FFF_FFFF);

		// small capacity: fill to full, reject, read back, wrap both indexes
		write_capacity(cqc_pkg::CAP_W'(3));
		send_word(cqc_pkg::OP_ENQ, 32'sh7FFF_FFFF);
		send_word(cqc_pkg::OP_ENQ, 32'sh8000_0000);
		send_word(cqc_pkg::OP_ENQ, 32'sh0000_0000);
		send_word(cqc_pkg::OP_ENQ, -32'sd1);
		send_word(cqc_pkg::OP_PEEK, $urandom());
		send_word(cqc_pkg::OP_DISP, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_ENQ, 32'sh5555_5555);
		send_word(cqc_pkg::OP_DISP, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());
		send_word(cqc_pkg::OP_ENQ, 32'shAAAA_AAAA);
		send_word(cqc_pkg::OP_DISP, $urandom());
		send_word(cqc_pkg::OP_DEQ, $urandom());

		// random phases, one capacity each, including zero and saturating writes
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(cqc_pkg::CAP_W'(phase_caps[p]));
			quiet_run = (p == PHASES - 1);
			idle_pct  = (p % 3 == 1) ? 0 : 25;
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 4 && n == 40)
					hold_request = 1'b1;
				if (p == 6 && n == 30)
					wait_drained();
				// flip between filling and draining at the ends, now and then mid-way
				if (filling ? (fill_level >= cap_now) : (fill_level == 0)) begin
					if ($urandom_range(0, 2) == 0)
						filling = !filling;
				end else if ($urandom_range(0, 99) < 3) begin
					filling = !filling;
				end
				send_word(next_request_op(), $urandom());
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: a hung handshake or a missing result word ends here.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
